### rtl/mcrp_pkg.sv
// Shared constants and types of the motor command ramp and PWM block.
`default_nettype none

package mcrp_pkg;

  localparam int MCRP_NCH      = 4;      // channel slots in every transaction
  localparam int MCRP_CHANNELS = 4;      // channels that are actually driven
  localparam int TGT_W         = 17;
  localparam int CUR_W         = 16;
  localparam int STEP_W        = 18;
  localparam int CNT_W         = 8;
  localparam int DUTY_W        = 8;
  localparam int FULL_SCALE    = 25600;  // 100.0 in 8 fraction bits
  localparam int RAMP_RESET    = 10;
  localparam int DIV_ITERS     = STEP_W;
  localparam int RECIP_100     = 5243;   // ceil(2^19 / 100)
  localparam int RECIP_SHIFT   = 19;

  typedef struct packed {
    logic              valid;
    logic [DUTY_W-1:0] duty;
    logic              forward;
  } lane_res_t;

endpackage

`default_nettype wire

### rtl/mcrp_channel_if.sv
// Handshake channels of the motor command ramp and PWM block.
`default_nettype none

interface mcrp_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] target_a;
  logic signed [16:0] target_b;
  logic signed [16:0] target_c;
  logic signed [16:0] target_d;

  modport source (output valid, target_a, target_b, target_c, target_d, input ready);
  modport sink   (input valid, target_a, target_b, target_c, target_d, output ready);
endinterface

interface mcrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_a;
  logic [7:0] duty_b;
  logic [7:0] duty_c;
  logic [7:0] duty_d;
  logic       forward_a;
  logic       forward_b;
  logic       forward_c;
  logic       forward_d;

  modport source (output valid, duty_a, duty_b, duty_c, duty_d,
                  forward_a, forward_b, forward_c, forward_d, input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, duty_d,
                  forward_a, forward_b, forward_c, forward_d, output ready);
endinterface

interface mcrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] ramp_steps;

  modport source (output valid, ramp_steps, input ready);
  modport sink   (input valid, ramp_steps, output ready);
endinterface

`default_nettype wire

### rtl/motor_command_ramp_pwm_top.sv
// Top level of the motor command ramp and PWM block.
// Each input transaction is one control tick with four signed targets (8 fraction bits).
// Every driven channel has its own lane that ramps its current value toward the target
// in ramp_steps equal steps, clamps it to +/-100.0 and turns it into a PWM duty and a
// direction bit; one result transaction leaves per tick. A tick passes through the
// radix-2 step divider in each lane, then update, duty scaling and merge. The next tick
// is accepted in the cycle after the lanes hand their results to the output register;
// that hand-over waits while the result side stalls, so no tick is taken until the last
// one is handed over. Channels at or beyond CHANNELS report zero duty and zero
// direction. ramp_steps resets to 10; a value of 0 acts as 1. Write it only while
// no tick is in flight.
`default_nettype none

module motor_command_ramp_pwm_top #(
  parameter int CHANNELS = mcrp_pkg::MCRP_CHANNELS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mcrp_in_if.sink    in_ch,
  mcrp_out_if.source out_ch,
  mcrp_cfg_if.sink   cfg_ch
);
  import mcrp_pkg::*;

  logic [CNT_W-1:0]        ramp_steps_r;
  logic [CNT_W-1:0]        steps_eff;
  logic                    busy_r;
  logic                    accept;
  logic                    load;
  logic signed [TGT_W-1:0] targets [MCRP_NCH];
  lane_res_t               res     [MCRP_NCH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_steps_r <= CNT_W'(RAMP_RESET);
    end else if (cfg_ch.valid) begin
      ramp_steps_r <= cfg_ch.ramp_steps;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign steps_eff    = (ramp_steps_r == '0) ? CNT_W'(1) : ramp_steps_r;

  // one tick in flight: hold off input until the lanes hand over their results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (load) begin
      busy_r <= 1'b0;
    end
  end

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  assign targets[0] = in_ch.target_a;
  assign targets[1] = in_ch.target_b;
  assign targets[2] = in_ch.target_c;
  assign targets[3] = in_ch.target_d;

  for (genvar g = 0; g < MCRP_NCH; g++) begin : g_lane
    if (g < CHANNELS) begin : g_used
      mcrp_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .ack        (load),
        .ramp_steps (steps_eff),
        .target     (targets[g]),
        .res        (res[g])
      );
    end else begin : g_unused
      assign res[g] = '{valid: 1'b1, duty: '0, forward: 1'b0};
    end
  end

  mcrp_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .load   (load),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### rtl/mcrp_lane.sv
// One channel lane: serial step divider, ramp update, clamp and duty scaling.
`default_nettype none

module mcrp_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            ack,
  input  wire logic [mcrp_pkg::CNT_W-1:0]      ramp_steps,
  input  wire logic signed [mcrp_pkg::TGT_W-1:0] target,
  output mcrp_pkg::lane_res_t                  res
);
  import mcrp_pkg::*;

  localparam int ITER_W = $clog2(DIV_ITERS);
  localparam int SUM_W  = STEP_W + 1;
  localparam int MAG_W  = CUR_W - 1;
  localparam int PROD_W = 28;
  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(FULL_SCALE);
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_DIV  = 3'd1;
  localparam logic [2:0] L_UPD  = 3'd2;
  localparam logic [2:0] L_DUTY = 3'd3;
  localparam logic [2:0] L_DONE = 3'd4;

  logic [2:0]                state_r;
  logic [ITER_W-1:0]         iter_r;
  logic signed [TGT_W-1:0]   tgt_r;
  logic signed [TGT_W-1:0]   last_tgt_r;
  logic signed [CUR_W-1:0]   cur_r;
  logic signed [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          div_r;
  logic [STEP_W-1:0]         dvd_r;
  logic [CNT_W-1:0]          rem_r;
  logic                      neg_r;
  logic                      fwd_r;
  logic [PROD_W-1:0]         prod_r;

  logic signed [STEP_W-1:0]  num;
  logic [STEP_W-1:0]         num_mag;
  logic [CNT_W:0]            rem_sh;
  logic [CNT_W:0]            rem_sub;
  logic                      fits;
  logic signed [STEP_W-1:0]  quot;
  logic                      changed;
  logic                      do_add;
  logic signed [STEP_W-1:0]  add_src;
  logic signed [SUM_W-1:0]   sum;
  logic signed [CUR_W-1:0]   cur_nxt;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W+7:0]          x255;
  logic [MAG_W-1:0]          scaled;

  always_comb begin
    num     = STEP_W'(target) - STEP_W'(cur_r);
    num_mag = num[STEP_W-1] ? STEP_W'(-num) : STEP_W'(num);

    rem_sh  = {rem_r, dvd_r[STEP_W-1]};
    fits    = (rem_sh >= {1'b0, div_r});
    rem_sub = rem_sh - {1'b0, div_r};

    quot    = neg_r ? -$signed(dvd_r) : $signed(dvd_r);
    changed = (tgt_r != last_tgt_r);
    do_add  = changed || (cnt_r < div_r);
    add_src = changed ? quot : step_r;
    sum     = SUM_W'(cur_r) + (do_add ? SUM_W'(add_src) : '0);

    if (sum < NEG_LIM) begin
      cur_nxt = CUR_W'(NEG_LIM);
    end else if (sum > POS_LIM) begin
      cur_nxt = CUR_W'(POS_LIM);
    end else begin
      cur_nxt = CUR_W'(sum);
    end

    // |cur| * 255 / 256, then divide by 100 with a reciprocal
    mag    = cur_r[CUR_W-1] ? MAG_W'(-cur_r) : MAG_W'(cur_r);
    x255   = {mag, 8'd0} - {8'd0, mag};
    scaled = x255[MAG_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= L_IDLE;
      iter_r     <= '0;
      last_tgt_r <= '0;
      cur_r      <= '0;
      step_r     <= '0;
      cnt_r      <= '0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            state_r <= L_DIV;
            iter_r  <= '0;
          end
        end
        L_DIV: begin
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_W'(DIV_ITERS - 1)) begin
            state_r <= L_UPD;
          end
        end
        L_UPD: begin
          if (changed) begin
            step_r <= quot;
            cnt_r  <= CNT_W'(1);
          end else if (cnt_r < div_r) begin
            cnt_r <= cnt_r + 1'b1;
          end
          last_tgt_r <= tgt_r;
          cur_r      <= cur_nxt;
          state_r    <= L_DUTY;
        end
        L_DUTY: begin
          state_r <= L_DONE;
        end
        L_DONE: begin
          if (ack) begin
            state_r <= L_IDLE;
          end
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && start) begin
      tgt_r <= target;
      div_r <= ramp_steps;
      dvd_r <= num_mag;
      neg_r <= num[STEP_W-1];
      rem_r <= '0;
    end else if (state_r == L_DIV) begin
      // shift in one dividend bit, subtract when it fits
      rem_r <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r <= {dvd_r[STEP_W-2:0], fits};
    end
    if (state_r == L_DUTY) begin
      prod_r <= PROD_W'(scaled) * PROD_W'(RECIP_100);
      fwd_r  <= (cur_r > 0);
    end
  end

  assign res.valid   = (state_r == L_DONE);
  assign res.duty    = prod_r[RECIP_SHIFT +: DUTY_W];
  assign res.forward = fwd_r;

endmodule

`default_nettype wire

### rtl/mcrp_merge.sv
// Merge stage: collects the lane results into the registered result channel.
`default_nettype none

module mcrp_merge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  mcrp_pkg::lane_res_t     res [mcrp_pkg::MCRP_NCH],
  output logic                    load,
  mcrp_out_if.source              out_ch
);
  import mcrp_pkg::*;

  logic              out_valid_r;
  logic [DUTY_W-1:0] duty_r [MCRP_NCH];
  logic              fwd_r  [MCRP_NCH];
  logic              all_done;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < MCRP_NCH; i++) begin
      all_done = all_done & res[i].valid;
    end
  end

  // take the lane results once every lane is done and the output slot is free
  assign load = all_done && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MCRP_NCH; i++) begin
        duty_r[i] <= res[i].duty;
        fwd_r[i]  <= res[i].forward;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.duty_a    = duty_r[0];
  assign out_ch.duty_b    = duty_r[1];
  assign out_ch.duty_c    = duty_r[2];
  assign out_ch.duty_d    = duty_r[3];
  assign out_ch.forward_a = fwd_r[0];
  assign out_ch.forward_b = fwd_r[1];
  assign out_ch.forward_c = fwd_r[2];
  assign out_ch.forward_d = fwd_r[3];

endmodule

`default_nettype wire

### tb/sv/ramp_pwm_checker.sv
// Checker: predicts ramp, clamp and PWM results and compares every result transaction.
`timescale 1ns / 100ps

module ramp_pwm_checker
  import mcrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mcrp_in_if   in_ch,
  mcrp_out_if  out_ch,
  mcrp_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);

  localparam int DUTY_FULL = 255;

  typedef struct packed {
    logic [MCRP_NCH-1:0][DUTY_W-1:0] duty;
    logic [MCRP_NCH-1:0]             fwd;
  } pwm_word_t;

  logic [CNT_W-1:0] ramp_reg;
  int               last_tgt [MCRP_NCH];
  int               cur_val  [MCRP_NCH];
  int               step_val [MCRP_NCH];
  int               done_cnt [MCRP_NCH];
  pwm_word_t        duty_q [$];
  pwm_word_t        seen;
  pwm_word_t        want;

  // Advance every driven channel by one control tick and form its duty and direction.
  function automatic pwm_word_t advance_ramps(input logic [MCRP_NCH-1:0][TGT_W-1:0] tgts);
    pwm_word_t w;
    int        lim;
    int        tgt;
    int        cur;
    int        mag;
    w   = '0;
    lim = (ramp_reg == 0) ? 1 : int'(ramp_reg);
    for (int ch = 0; ch < MCRP_CHANNELS; ch++) begin
      tgt = int'($signed(tgts[ch]));
      cur = cur_val[ch];
      if (tgt != last_tgt[ch]) begin
        step_val[ch] = (tgt - cur) / lim;
        cur          = cur + step_val[ch];
        done_cnt[ch] = 1;
      end else if (done_cnt[ch] < lim) begin
        cur          = cur + step_val[ch];
        done_cnt[ch] = done_cnt[ch] + 1;
      end
      last_tgt[ch] = tgt;
      if (cur < -FULL_SCALE) cur = -FULL_SCALE;
      if (cur > FULL_SCALE) cur = FULL_SCALE;
      cur_val[ch] = cur;
      mag         = (cur < 0) ? -cur : cur;
      w.duty[ch]  = DUTY_W'((mag * DUTY_FULL) / FULL_SCALE);
      w.fwd[ch]   = (cur > 0);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ramp_reg = CNT_W'(RAMP_RESET);
      for (int ch = 0; ch < MCRP_NCH; ch++) begin
        last_tgt[ch] = 0;
        cur_val[ch]  = 0;
        step_val[ch] = 0;
        done_cnt[ch] = 0;
      end
      duty_q.delete();
    end else begin
      // Retire results before queuing new ticks, so a result can never match its own tick.
      if (out_ch.valid && out_ch.ready) begin
        seen.duty = {out_ch.duty_d, out_ch.duty_c, out_ch.duty_b, out_ch.duty_a};
        seen.fwd  = {out_ch.forward_d, out_ch.forward_c, out_ch.forward_b, out_ch.forward_a};
        if (duty_q.size() == 0) begin
          $display("%0t: result transaction with no tick outstanding: expected none, got %h",
                   $time, seen);
          errors++;
        end else begin
          want = duty_q.pop_front();
          for (int ch = 0; ch < MCRP_NCH; ch++) begin
            if (seen.duty[ch] !== want.duty[ch]) begin
              $display("%0t: duty of channel %0d: expected %0d, got %0d",
                       $time, ch, want.duty[ch], seen.duty[ch]);
              errors++;
            end
            if (seen.fwd[ch] !== want.fwd[ch]) begin
              $display("%0t: forward of channel %0d: expected %0b, got %0b",
                       $time, ch, want.fwd[ch], seen.fwd[ch]);
              errors++;
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) ramp_reg = cfg_ch.ramp_steps;
      if (in_ch.valid && in_ch.ready) begin
        duty_q.push_back(advance_ramps({in_ch.target_d, in_ch.target_c,
                                        in_ch.target_b, in_ch.target_a}));
      end
    end
    pending = duty_q.size();
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, tick and ramp_steps stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module testbench;
  import mcrp_pkg::*;

  typedef logic [MCRP_NCH-1:0][TGT_W-1:0] tick_t;

  localparam int PHASE_TICKS = 75;
  localparam int LONG_HOLD   = 300;
  localparam int CORNERS [12] = '{-65536, 65535, -25600, 25600, -25601, 25601,
                                  0, 1, -1, 100, -100, 65280};

  logic  clk;
  logic  rst_n;
  int    mismatch_count;
  int    ticks_in_flight;
  bit    tx_no_idle;
  bit    rx_no_idle;
  bit    hold_go;
  tick_t walk;

  mcrp_in_if  in_ch ();
  mcrp_out_if out_ch ();
  mcrp_cfg_if cfg_ch ();

  motor_command_ramp_pwm_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ramp_pwm_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (mismatch_count),
    .pending (ticks_in_flight)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic tick_t quad(input int a, input int b, input int c, input int d);
    tick_t t;
    t[0] = TGT_W'(a);
    t[1] = TGT_W'(b);
    t[2] = TGT_W'(c);
    t[3] = TGT_W'(d);
    return t;
  endfunction

  function automatic logic [TGT_W-1:0] fresh_target();
    int r;
    r = $urandom_range(99);
    if (r < 35) return TGT_W'(int'($urandom_range(2 * FULL_SCALE)) - FULL_SCALE);
    if (r < 50) return TGT_W'(CORNERS[$urandom_range(11)]);
    return TGT_W'($urandom);
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.target_a = t[0];
    in_ch.target_b = t[1];
    in_ch.target_c = t[2];
    in_ch.target_d = t[3];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every outstanding tick has returned its result.
  task automatic drain_ticks();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (ticks_in_flight == 0);
  endtask

  task automatic write_ramp(input int steps);
    drain_ticks();
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.ramp_steps = CNT_W'(steps);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_repeat(input tick_t t, input int n);
    repeat (n) send_tick(t);
  endtask

  // Most channels keep their target so ramps run to completion; the rest jump.
  task automatic random_ticks(input int n);
    repeat (n) begin
      for (int ch = 0; ch < MCRP_NCH; ch++) begin
        if ($urandom_range(99) >= 80) walk[ch] = fresh_target();
      end
      send_tick(walk);
    end
  endtask

  // Result side: random stalls, and a long hold-off on request.
  initial begin
    int run_left;
    int stall_left;
    run_left     = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go    = 1'b0;
        stall_left = LONG_HOLD;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(40, 1);
          stall_left = rx_no_idle ? 0 : pick_gap();
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.target_a    = '0;
    in_ch.target_b    = '0;
    in_ch.target_c    = '0;
    in_ch.target_d    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.ramp_steps = '0;
    tx_no_idle        = 1'b0;
    rx_no_idle        = 1'b0;
    hold_go           = 1'b0;
    walk              = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unchanged zero target, field extremes, clamp, ramp at reset steps.
    send_tick(quad(0, 0, 0, 0));
    send_repeat(quad(65535, -65536, 25600, -25600), 4);
    send_tick(quad(-1, 1, 0, 12345));
    // Zero steps acts as one: full jump in a single tick, then clamp.
    write_ramp(0);
    send_repeat(quad(65535, -65536, -25601, 25601), 2);
    send_tick(quad(0, 0, 0, 0));
    // Longest ramp, then lower the limit below the count already done.
    write_ramp(255);
    send_repeat(quad(25600, -25600, 300, -300), 5);
    write_ramp(2);
    send_repeat(quad(25600, -25600, 300, -300), 2);
    // Count reached: value holds while the target stays.
    send_repeat(quad(-12800, 12800, -1, 1), 4);
    write_ramp(1);
    send_repeat(quad(255, -255, -256, 256), 2);

    // Random phases over several step counts.
    write_ramp(10);
    random_ticks(PHASE_TICKS);

    write_ramp(3);
    // Hold the result side off while ticks keep coming so the input stalls.
    hold_go    = 1'b1;
    tx_no_idle = 1'b1;
    random_ticks(30);
    tx_no_idle = 1'b0;
    random_ticks(PHASE_TICKS - 30);

    write_ramp(255);
    random_ticks(PHASE_TICKS);

    write_ramp(0);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    random_ticks(PHASE_TICKS);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    write_ramp($urandom_range(254, 4));
    random_ticks(PHASE_TICKS);

    write_ramp(1);
    random_ticks(PHASE_TICKS);

    drain_ticks();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && ticks_in_flight == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### motor_command_ramp_pwm_top.f
rtl/mcrp_pkg.sv
rtl/mcrp_channel_if.sv
rtl/mcrp_lane.sv
rtl/mcrp_merge.sv
rtl/motor_command_ramp_pwm_top.sv
tb/sv/ramp_pwm_checker.sv
tb/sv/testbench.sv
